FILE: design/ualist_pkg.sv
// ----------------------------------------------------------------------------
// ualist_pkg
// Shared types and codes for the unordered array list engine.
// ----------------------------------------------------------------------------
package ualist_pkg;

    localparam int DEF_CAPACITY = 256;

    typedef enum logic [2:0] {
        ACT_APPEND   = 3'd0,
        ACT_INSERT   = 3'd1,
        ACT_DEL_AT   = 3'd2,
        ACT_DEL_VAL  = 3'd3,
        ACT_DEL_LAST = 3'd4,
        ACT_CLEAR    = 3'd5,
        ACT_SEARCH   = 3'd6
    } t_action;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BADPOS    = 2'd1,
        ST_NOTFOUND  = 2'd2,
        ST_FULLEMPTY = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_INS_RD,
        S_INS_WR,
        S_DEL_RD,
        S_SCAN,
        S_OUT
    } t_state;

    typedef struct packed {
        t_action             action;
        logic [8:0]          position;
        logic signed [31:0]  value;
    } t_in_word;

    typedef struct packed {
        t_status             status;
        logic [7:0]          found_index;
        logic signed [31:0]  data;
        logic [8:0]          count;
    } t_out_word;

endpackage

FILE: design/ualist_ram.sv
// ----------------------------------------------------------------------------
// ualist_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ualist_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/unordered_array_list_engine.sv
// Sequence: append, delete last, clear and refused actions pass S_DECIDE and
//   S_OUT; delete at adds S_DEL_RD; insert at an occupied position adds S_INS_RD
//   and S_INS_WR; search and delete by value add S_SCAN over up to count entries.
// Throughput: one word in flight; the entry RAM's single read port sets the
//   scan rate of one entry per cycle.
// Reset: synchronous, active low; count cleared, RAM contents left as is.
// ----------------------------------------------------------------------------
// unordered_array_list_engine
// Fixed-capacity unordered list of 32-bit words with swap-on-delete.
// ----------------------------------------------------------------------------
module unordered_array_list_engine
    import ualist_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out
);

    // AW addresses the entry RAM, CW holds a count up to CAPACITY itself.
    localparam int AW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > 9) ? CW : 9;

    // Control
    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic [CW-1:0] r_count, n_count;

    // Latched input word and scan bookkeeping
    t_action            r_act, n_act;
    logic [8:0]         r_pos, n_pos;
    logic signed [31:0] r_val, n_val;
    logic [AW-1:0]      r_idx, n_idx;   // index of the entry now on the read port
    logic [AW-1:0]      r_tgt, n_tgt;   // hole to be filled by the last entry

    // Pending result fields
    t_status            r_res_status, n_res_status;
    logic [7:0]         r_res_found, n_res_found;
    logic signed [31:0] r_res_data, n_res_data;
    t_out_word          r_out, n_out;

    // RAM port
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [31:0]   ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [31:0]   ram_rdata;

    logic [CW-1:0]   count_m1;
    logic [AW-1:0]   last_addr;
    logic [CMPW-1:0] pos_c, cnt_c;
    logic            full;

    assign count_m1  = r_count - CW'(1);
    assign last_addr = AW'(count_m1);
    assign pos_c     = CMPW'(r_pos);
    assign cnt_c     = CMPW'(r_count);
    assign full      = (r_count == CW'(CAPACITY));

    ualist_ram #(
        .WIDTH (32),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_count     <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_act        <= n_act;
        r_pos        <= n_pos;
        r_val        <= n_val;
        r_idx        <= n_idx;
        r_tgt        <= n_tgt;
        r_res_status <= n_res_status;
        r_res_found  <= n_res_found;
        r_res_data   <= n_res_data;
        r_out        <= n_out;
    end

    always_comb begin
        n_state      = r_state;
        n_out_valid  = r_out_valid;
        n_count      = r_count;
        n_act        = r_act;
        n_pos        = r_pos;
        n_val        = r_val;
        n_idx        = r_idx;
        n_tgt        = r_tgt;
        n_res_status = r_res_status;
        n_res_found  = r_res_found;
        n_res_data   = r_res_data;
        n_out        = r_out;
        ram_we       = 1'b0;
        ram_waddr    = '0;
        ram_wdata    = '0;
        ram_raddr    = '0;

        // Output register drains whenever the sink takes the word.
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_act        = i_in.action;
                    n_pos        = i_in.position;
                    n_val        = i_in.value;
                    n_res_status = ST_OK;
                    n_res_found  = '0;
                    n_res_data   = '0;
                    n_state      = S_DECIDE;
                end
            end

            S_DECIDE: begin
                n_state = S_OUT;
                unique case (r_act) inside
                    ACT_APPEND: begin
                        if (full) begin
                            n_res_status = ST_FULLEMPTY;
                        end else begin
                            ram_we    = 1'b1;
                            ram_waddr = AW'(r_count);
                            ram_wdata = r_val;
                            n_count   = r_count + CW'(1);
                        end
                    end
                    ACT_INSERT: begin
                        // Position check wins over the full check.
                        if (pos_c > cnt_c) begin
                            n_res_status = ST_BADPOS;
                        end else if (full) begin
                            n_res_status = ST_FULLEMPTY;
                        end else if (pos_c == cnt_c) begin
                            ram_we    = 1'b1;
                            ram_waddr = AW'(r_count);
                            ram_wdata = r_val;
                            n_count   = r_count + CW'(1);
                        end else begin
                            // Fetch the displaced entry; it moves to the end.
                            ram_raddr = AW'(r_pos);
                            n_state   = S_INS_RD;
                        end
                    end
                    ACT_DEL_AT: begin
                        if (pos_c >= cnt_c) begin
                            n_res_status = ST_BADPOS;
                        end else begin
                            ram_raddr = last_addr;
                            n_tgt     = AW'(r_pos);
                            n_state   = S_DEL_RD;
                        end
                    end
                    ACT_DEL_VAL, ACT_SEARCH: begin
                        if (r_count == '0) begin
                            n_res_status = ST_NOTFOUND;
                        end else begin
                            ram_raddr = '0;
                            n_idx     = '0;
                            n_state   = S_SCAN;
                        end
                    end
                    ACT_DEL_LAST: begin
                        if (r_count == '0) begin
                            n_res_status = ST_FULLEMPTY;
                        end else begin
                            n_count = count_m1;
                        end
                    end
                    ACT_CLEAR: begin
                        n_count = '0;
                    end
                    default: begin
                        // unused code: no change, status ok
                    end
                endcase
            end

            S_INS_RD: begin
                ram_we    = 1'b1;
                ram_waddr = AW'(r_count);
                ram_wdata = ram_rdata;
                n_state   = S_INS_WR;
            end

            S_INS_WR: begin
                ram_we    = 1'b1;
                ram_waddr = AW'(r_pos);
                ram_wdata = r_val;
                n_count   = r_count + CW'(1);
                n_state   = S_OUT;
            end

            S_DEL_RD: begin
                // Last entry fills the hole.
                ram_we    = 1'b1;
                ram_waddr = r_tgt;
                ram_wdata = ram_rdata;
                n_count   = count_m1;
                if (r_act == ACT_DEL_AT) begin
                    n_res_data = ram_rdata;
                end
                n_state = S_OUT;
            end

            S_SCAN: begin
                if (ram_rdata == r_val) begin
                    if (r_act == ACT_SEARCH) begin
                        n_res_found = 8'(r_idx);
                        n_state     = S_OUT;
                    end else begin
                        ram_raddr = last_addr;
                        n_tgt     = r_idx;
                        n_state   = S_DEL_RD;
                    end
                end else if (CW'(r_idx) == count_m1) begin
                    n_res_status = ST_NOTFOUND;
                    n_state      = S_OUT;
                end else begin
                    ram_raddr = r_idx + AW'(1);
                    n_idx     = r_idx + AW'(1);
                end
            end

            S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid       = 1'b1;
                    n_out.status      = r_res_status;
                    n_out.found_index = r_res_found;
                    n_out.data        = r_res_data;
                    n_out.count       = 9'(r_count);
                    n_state           = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

FILE: design/ualist_chk.sv
// ----------------------------------------------------------------------------
// ualist_chk
// Port-level checks for the unordered array list engine.
// ----------------------------------------------------------------------------
module ualist_chk
    import ualist_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input t_in_word  i_in,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_word o_out
);

    // No output word survives reset.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output word valid after reset");

    // Stalled output word holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out)))
        else $error("stalled output word changed");

    // One word at a time: input closes right after an accept.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("second word accepted while busy");

    // A new result only appears at the end of a busy phase.
    a_out_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result without work");

    // Index and data fields carry something only on success.
    a_fields_on_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out.found_index != '0 || o_out.data != '0))
            |-> (o_out.status == ST_OK))
        else $error("payload on failed action");

endmodule

bind unordered_array_list_engine ualist_chk u_ualist_chk (.*);
